// File: sv/trb_pkg.sv
// Shared types and codes for the ticket reorder buffer.
`timescale 1ns / 1ps
`default_nettype none

package trb_pkg;

   // Width of the capacity register and of the reported outstanding count.
   localparam int CAP_W = 5;

   // Operation codes carried in the kind field.
   localparam logic [2:0] KIND_SUBMIT   = 3'd0;
   localparam logic [2:0] KIND_COMPLETE = 3'd1;
   localparam logic [2:0] KIND_COLLECT  = 3'd2;
   localparam logic [2:0] KIND_RESET    = 3'd3;
   localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

   // Result codes.
   localparam logic [2:0] RC_OK        = 3'd0;
   localparam logic [2:0] RC_SHUT      = 3'd1;
   localparam logic [2:0] RC_FULL      = 3'd2;
   localparam logic [2:0] RC_EMPTY     = 3'd3;
   localparam logic [2:0] RC_NOT_READY = 3'd4;
   localparam logic [2:0] RC_ERROR     = 3'd5;

   // One request beat.
   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        payload;
      logic [63:0]        ticket;
      logic signed [31:0] status_value;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic [2:0]         result_code;
      logic [63:0]        issued_ticket;
      logic [31:0]        retired_payload;
      logic signed [31:0] retired_status;
      logic [CAP_W-1:0]   outstanding_count;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ
   } ctl_state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic read;
      logic commit_check;
      logic commit_read;
   } trb_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic needs_ram;
   } trb_status_type;

endpackage

`default_nettype wire

// File: sv/trb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module trb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/trb_ctrl.sv
// Sequencer for the ticket reorder buffer: request, slot read and response timing.
`timescale 1ns / 1ps
`default_nettype none

module trb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire trb_pkg::trb_status_type status,
   output trb_pkg::trb_cmd_type         cmd
);

   trb_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // The response register can take a new beat when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = trb_pkg::ST_CHECK;
            end
         end
         trb_pkg::ST_CHECK: begin
            if (status.needs_ram) begin
               state_in = trb_pkg::ST_READ;
            end else if (out_free) begin
               state_in = trb_pkg::ST_IDLE;
            end
         end
         trb_pkg::ST_READ: begin
            if (out_free) begin
               state_in = trb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trb_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_ready        = 1'b0;
      cmd.capture      = 1'b0;
      cmd.read         = 1'b0;
      cmd.commit_check = 1'b0;
      cmd.commit_read  = 1'b0;
      case (state_ff)
         trb_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         trb_pkg::ST_CHECK: begin
            cmd.read         = status.needs_ram;
            cmd.commit_check = !status.needs_ram && out_free;
         end
         trb_pkg::ST_READ: begin
            cmd.commit_read = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Response valid flag: set on a commit, cleared when the beat is taken.
   always_comb begin
      if (cmd.commit_check || cmd.commit_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: sv/trb_dp.sv
// Datapath for the ticket reorder buffer: counters, ring pointers, slot RAM and response register.
`timescale 1ns / 1ps
`default_nettype none

module trb_dp #(
   parameter int RING_DEPTH   = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire trb_pkg::req_type            req_data,
   input  wire trb_pkg::trb_cmd_type        cmd,
   output trb_pkg::trb_status_type          status,
   input  wire logic                        csr_wr_en,
   input  wire logic [trb_pkg::CAP_W-1:0]   csr_wr_data,
   output trb_pkg::rsp_type                 rsp_data
);

   localparam int IDX_W     = $clog2(RING_DEPTH);
   localparam int CNT_W     = $clog2(RING_DEPTH + 1);
   localparam int SLOT_BITS = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
   localparam int ENTRY_W   = SLOT_BITS + 33;
   localparam int CMP_W     = (CNT_W > trb_pkg::CAP_W) ? CNT_W : trb_pkg::CAP_W;
   localparam int DONE_BIT  = ENTRY_W - 1;

   // Registers.
   trb_pkg::req_type          req_ff, req_in;
   trb_pkg::rsp_type          rsp_ff, rsp_in;
   logic [trb_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                      shut_ff, shut_in;
   logic [63:0]               issue_ff, issue_in;
   logic [63:0]               retire_ff, retire_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [IDX_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          slot_ff, slot_in;

   // Combinational signals.
   logic [63:0]      win_diff;
   logic             in_window;
   logic [IDX_W:0]   tgt_sum;
   logic [IDX_W-1:0] tgt_slot;
   logic [IDX_W-1:0] head_inc;
   logic [IDX_W-1:0] tail_inc;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] cnt_out_ext;
   logic             cap_hit;
   logic             ring_full;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic             rd_done;
   logic [31:0]      rd_status;
   logic [31:0]      rd_payload_ext;
   logic [2:0]       code;
   logic [63:0]      tick_out;
   logic [31:0]      pay_out;
   logic [31:0]      stat_out;

   // Ticket window check and slot of the ticket, counted from the head slot.
   assign win_diff  = req_ff.ticket - retire_ff;
   assign in_window = win_diff < 64'(count_ff);
   assign tgt_sum   = {1'b0, head_ff} + {1'b0, win_diff[IDX_W-1:0]};
   always_comb begin
      if (tgt_sum >= (IDX_W + 1)'(RING_DEPTH)) begin
         tgt_slot = IDX_W'(tgt_sum - (IDX_W + 1)'(RING_DEPTH));
      end else begin
         tgt_slot = tgt_sum[IDX_W-1:0];
      end
   end

   // Ring pointer increments with wrap at the ring depth.
   assign head_inc = (head_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc = (tail_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   // Capacity and ring occupancy checks at a common width.
   always_comb begin
      cap_ext = '0;
      cnt_ext = '0;
      cap_ext[trb_pkg::CAP_W-1:0] = cap_ff;
      cnt_ext[CNT_W-1:0]          = count_ff;
   end
   assign cap_hit   = (cap_ff != '0) && (cnt_ext >= cap_ext);
   assign ring_full = count_ff == CNT_W'(RING_DEPTH);

   // Only a complete inside the window or a collect with work pending reads a slot.
   assign status.needs_ram = !shut_ff &&
                             (((req_ff.kind == trb_pkg::KIND_COMPLETE) && in_window) ||
                              ((req_ff.kind == trb_pkg::KIND_COLLECT) && (count_ff != '0)));

   assign rd_addr = (req_ff.kind == trb_pkg::KIND_COLLECT) ? head_ff : tgt_slot;

   // Fields of the slot entry read back.
   assign rd_done   = rd_data[DONE_BIT];
   assign rd_status = rd_data[SLOT_BITS+31:SLOT_BITS];
   always_comb begin
      rd_payload_ext = '0;
      rd_payload_ext[SLOT_BITS-1:0] = rd_data[SLOT_BITS-1:0];
   end

   // Operation decode and state update.
   always_comb begin
      req_in    = cmd.capture ? req_data : req_ff;
      slot_in   = cmd.read ? tgt_slot : slot_ff;
      cap_in    = csr_wr_en ? csr_wr_data : cap_ff;
      shut_in   = shut_ff;
      issue_in  = issue_ff;
      retire_in = retire_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      wr_data   = '0;
      code      = trb_pkg::RC_OK;
      tick_out  = '0;
      pay_out   = '0;
      stat_out  = '0;

      if (cmd.commit_check) begin
         if (req_ff.kind == trb_pkg::KIND_SHUTDOWN) begin
            shut_in = 1'b1;
         end else if (req_ff.kind > trb_pkg::KIND_SHUTDOWN) begin
            code = trb_pkg::RC_ERROR;
         end else if (shut_ff) begin
            code = trb_pkg::RC_SHUT;
         end else begin
            case (req_ff.kind)
               trb_pkg::KIND_SUBMIT: begin
                  if (cap_hit) begin
                     code = trb_pkg::RC_FULL;
                  end else if (ring_full) begin
                     code = trb_pkg::RC_ERROR;
                  end else begin
                     // New entry: not done, status zero.
                     wr_en    = 1'b1;
                     wr_addr  = tail_ff;
                     wr_data  = {1'b0, 32'd0, req_ff.payload[SLOT_BITS-1:0]};
                     tick_out = issue_ff;
                     issue_in = issue_ff + 64'd1;
                     tail_in  = tail_inc;
                     count_in = count_ff + 1'b1;
                  end
               end
               trb_pkg::KIND_COMPLETE: begin
                  // Reached here only with the ticket outside the window.
                  code = trb_pkg::RC_ERROR;
               end
               trb_pkg::KIND_COLLECT: begin
                  // Reached here only with nothing outstanding.
                  code = trb_pkg::RC_EMPTY;
               end
               trb_pkg::KIND_RESET: begin
                  issue_in  = '0;
                  retire_in = '0;
                  head_in   = '0;
                  tail_in   = '0;
                  count_in  = '0;
               end
               default: begin
                  code = trb_pkg::RC_ERROR;
               end
            endcase
         end
      end else if (cmd.commit_read) begin
         if (req_ff.kind == trb_pkg::KIND_COMPLETE) begin
            if (rd_done) begin
               code = trb_pkg::RC_ERROR;
            end else begin
               // Keep the stored payload, record the status and mark done.
               wr_en   = 1'b1;
               wr_addr = slot_ff;
               wr_data = {1'b1, req_ff.status_value, rd_data[SLOT_BITS-1:0]};
            end
         end else begin
            if (!rd_done) begin
               code = trb_pkg::RC_NOT_READY;
            end else begin
               pay_out   = rd_payload_ext;
               stat_out  = rd_status;
               retire_in = retire_ff + 64'd1;
               head_in   = head_inc;
               count_in  = count_ff - 1'b1;
            end
         end
      end

      cnt_out_ext = '0;
      cnt_out_ext[CNT_W-1:0] = count_in;
      if (cmd.commit_check || cmd.commit_read) begin
         rsp_in.result_code       = code;
         rsp_in.issued_ticket     = tick_out;
         rsp_in.retired_payload   = pay_out;
         rsp_in.retired_status    = stat_out;
         rsp_in.outstanding_count = cnt_out_ext[trb_pkg::CAP_W-1:0];
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= '0;
         shut_ff   <= 1'b0;
         issue_ff  <= '0;
         retire_ff <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
      end else begin
         cap_ff    <= cap_in;
         shut_ff   <= shut_in;
         issue_ff  <= issue_in;
         retire_ff <= retire_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      slot_ff <= slot_in;
   end

   // Slot store: done flag, status and payload of each ring entry.
   trb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_data = rsp_ff;

   // The outstanding count never exceeds the ring depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("outstanding count beyond ring depth");

   // An empty ring has its head and tail on the same slot.
   a_empty_ptrs : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty ring with head and tail apart");

   // Shutdown is sticky until reset.
   a_shut_sticky : assert property (@(posedge clock) disable iff (reset)
      shut_ff |=> shut_ff)
      else $error("shutdown flag cleared");

   // A slot read and a commit never fall in the same cycle.
   a_read_commit : assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> !(cmd.commit_check || cmd.commit_read))
      else $error("slot read issued together with a commit");

endmodule

`default_nettype wire

// File: sv/ticket_reorder_buffer.sv
// Top level of the ticket reorder buffer.
//
// Requests arrive on the req_ channel (valid/ready), one operation per beat:
// submit, complete, collect, reset or shutdown. Each request produces exactly one
// response beat on the rsp_ channel, carrying the result code, the issued ticket,
// the retired payload and status, and the outstanding count after the operation.
// A request is taken only while the sequencer is idle. Any operation that needs no
// slot read loads the response register from the check state; a complete inside
// the ticket window or a collect of a non-empty ring first passes the read state,
// for the registered read of the slot RAM. The next request is accepted in the
// cycle after the response is loaded, so a new request is never taken before the
// current one is committed.
// The response register holds one beat; if the receiver stalls, the block may
// finish the next operation up to its commit and then waits there for space.
// csr_wr_en writes the capacity limit (zero means only the ring depth limits);
// write it only while the block is idle.
// Synchronous reset empties the ring, zeroes both ticket counters, clears the
// shutdown flag and the capacity limit. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ticket_reorder_buffer #(
   parameter int RING_DEPTH   = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire trb_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output trb_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [trb_pkg::CAP_W-1:0] csr_wr_data
);

   trb_pkg::trb_cmd_type    cmd;
   trb_pkg::trb_status_type status;

   // Sequencer.
   trb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   trb_dp #(
      .RING_DEPTH   (RING_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
